### hw/rtl/gbnw_pkg.sv
// Shared types, constants and cell arithmetic for the grid path planner.
package gbnw_pkg;

    localparam int GRID_SIDE  = 16;
    localparam int CELL_COUNT = 256;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int PTR_W      = CELL_W + 1;
    localparam int EXIT_W     = 4;
    localparam int DIR_W      = 3;
    localparam int NB_W       = 2;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [PTR_W-1:0]  t_ptr;
    typedef logic [EXIT_W-1:0] t_exits;
    typedef logic [DIR_W-1:0]  t_dir;
    typedef logic [NB_W-1:0]   t_nb;

    // Step codes kept per visited cell
    localparam t_dir DIR_NONE     = 3'd0;
    localparam t_dir DIR_TARGET   = 3'd1;
    localparam t_dir DIR_PLUS1    = 3'd2;
    localparam t_dir DIR_MINUS1   = 3'd3;
    localparam t_dir DIR_PLUSROW  = 3'd4;
    localparam t_dir DIR_MINUSROW = 3'd5;

    // Neighbor order follows the exit mask bits
    localparam t_nb NB_LEFT  = 2'd0;
    localparam t_nb NB_RIGHT = 2'd1;
    localparam t_nb NB_UP    = 2'd2;
    localparam t_nb NB_DOWN  = 2'd3;

    // Source of the returned waypoint
    typedef enum logic [1:0] {
        SEL_TARGET = 2'd0,
        SEL_START  = 2'd1,
        SEL_WALK   = 2'd2
    } t_sel;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic wr_exits;
        logic clr;
        logic clr_exits;
        logic init;
        logic deq;
        logic take;
        logic nb_rd;
        logic nb_next;
        logic visit;
        logic walk_dir;
        logic walk_step;
        logic emit;
        t_sel sel;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic eq;
        logic q_more;
        logic p_is_start;
        logic ex_bit;
        logic nb_last;
        logic same_dir;
        logic clr_last;
    } t_stat;

    // Move one step by code, wrapping over the whole grid
    function automatic t_cell cell_move(t_cell p, t_dir code);
        t_cell res;
        case (code)
            DIR_PLUS1:    res = p + t_cell'(1);
            DIR_MINUS1:   res = p - t_cell'(1);
            DIR_PLUSROW:  res = p + t_cell'(GRID_SIDE);
            DIR_MINUSROW: res = p - t_cell'(GRID_SIDE);
            default:      res = p;
        endcase
        return res;
    endfunction

    // Move that reaches a neighbor
    function automatic t_dir nb_move(t_nb nb);
        t_dir res;
        case (nb)
            NB_LEFT:  res = DIR_MINUS1;
            NB_RIGHT: res = DIR_PLUS1;
            NB_UP:    res = DIR_MINUSROW;
            default:  res = DIR_PLUSROW;
        endcase
        return res;
    endfunction

    // Step stored in a neighbor that leads back to the current cell
    function automatic t_dir nb_back(t_nb nb);
        t_dir res;
        case (nb)
            NB_LEFT:  res = DIR_PLUS1;
            NB_RIGHT: res = DIR_MINUS1;
            NB_UP:    res = DIR_PLUSROW;
            default:  res = DIR_MINUSROW;
        endcase
        return res;
    endfunction

endpackage

### hw/rtl/gbnw_dp.sv
// Datapath: exit, step and queue memories, queue pointers and walk registers.
module gbnw_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  gbnw_pkg::t_cmd        i_cmd,
    output gbnw_pkg::t_stat       o_stat,
    input  logic [7:0]            i_cell_req,
    input  logic [3:0]            i_exits,
    input  logic [7:0]            i_start_req,
    input  logic [7:0]            i_target,
    output logic                  o_valid,
    output logic [7:0]            o_waypoint
);

    gbnw_pkg::t_exits r_exits_mem [gbnw_pkg::CELL_COUNT];
    gbnw_pkg::t_dir   r_step_mem  [gbnw_pkg::CELL_COUNT];
    gbnw_pkg::t_cell  r_queue_mem [gbnw_pkg::CELL_COUNT];

    gbnw_pkg::t_exits r_ex_rd;
    gbnw_pkg::t_dir   r_step_rd;
    gbnw_pkg::t_cell  r_q_rd;

    gbnw_pkg::t_cell  r_start;
    gbnw_pkg::t_cell  r_target;
    gbnw_pkg::t_cell  r_p;
    gbnw_pkg::t_dir   r_dir;
    gbnw_pkg::t_nb    r_nb;
    gbnw_pkg::t_cell  r_clr;
    gbnw_pkg::t_ptr   r_rp;
    gbnw_pkg::t_ptr   r_wp;
    logic             r_valid;
    gbnw_pkg::t_cell  r_waypoint;

    gbnw_pkg::t_cell  nb_addr;
    gbnw_pkg::t_cell  walk_addr;
    gbnw_pkg::t_cell  step_raddr;
    logic             visit_ok;
    logic             step_we;
    gbnw_pkg::t_cell  step_waddr;
    gbnw_pkg::t_dir   step_wdata;
    logic             q_we;
    gbnw_pkg::t_cell  q_waddr;
    gbnw_pkg::t_cell  q_wdata;
    logic             ex_we;
    gbnw_pkg::t_cell  ex_waddr;
    gbnw_pkg::t_exits ex_wdata;
    gbnw_pkg::t_cell  n_waypoint;

    // Neighbor and walk addresses
    assign nb_addr   = gbnw_pkg::cell_move(r_p, gbnw_pkg::nb_move(r_nb));
    assign walk_addr = gbnw_pkg::cell_move(r_p, r_dir);
    assign visit_ok  = i_cmd.visit && (r_step_rd == gbnw_pkg::DIR_NONE)
                       && (r_wp < gbnw_pkg::t_ptr'(gbnw_pkg::CELL_COUNT));

    // Select step memory read address
    always_comb begin
        if (i_cmd.take) begin
            step_raddr = r_q_rd;
        end else if (i_cmd.nb_rd) begin
            step_raddr = nb_addr;
        end else if (i_cmd.walk_step) begin
            step_raddr = walk_addr;
        end else begin
            step_raddr = r_p;
        end
    end

    // Select step memory write
    always_comb begin
        step_we    = 1'b1;
        step_waddr = nb_addr;
        step_wdata = gbnw_pkg::nb_back(r_nb);
        if (i_cmd.clr) begin
            step_waddr = r_clr;
            step_wdata = gbnw_pkg::DIR_NONE;
        end else if (i_cmd.init) begin
            step_waddr = r_target;
            step_wdata = gbnw_pkg::DIR_TARGET;
        end else if (!visit_ok) begin
            step_we = 1'b0;
        end
    end

    // Select queue write
    always_comb begin
        q_we    = i_cmd.init || visit_ok;
        q_waddr = i_cmd.init ? '0 : r_wp[gbnw_pkg::CELL_W-1:0];
        q_wdata = i_cmd.init ? r_target : nb_addr;
    end

    // Select exit mask write
    always_comb begin
        ex_we    = i_cmd.wr_exits || i_cmd.clr_exits;
        ex_waddr = i_cmd.clr_exits ? r_clr : i_cell_req;
        ex_wdata = i_cmd.clr_exits ? '0 : i_exits;
    end

    // Exit mask memory
    always_ff @(posedge i_clk) begin
        if (ex_we) begin
            r_exits_mem[ex_waddr] <= ex_wdata;
        end
        if (i_cmd.take) begin
            r_ex_rd <= r_exits_mem[r_q_rd];
        end
    end

    // Step memory
    always_ff @(posedge i_clk) begin
        if (step_we) begin
            r_step_mem[step_waddr] <= step_wdata;
        end
        r_step_rd <= r_step_mem[step_raddr];
    end

    // Visit queue memory
    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue_mem[q_waddr] <= q_wdata;
        end
        if (i_cmd.deq) begin
            r_q_rd <= r_queue_mem[r_rp[gbnw_pkg::CELL_W-1:0]];
        end
    end

    // Pick the result cell
    always_comb begin
        case (i_cmd.sel)
            gbnw_pkg::SEL_TARGET: n_waypoint = r_target;
            gbnw_pkg::SEL_START:  n_waypoint = r_start;
            default:              n_waypoint = r_p;
        endcase
    end

    // Control registers: pointers, sweep counter, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp    <= '0;
            r_wp    <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.clr) begin
                r_clr <= r_clr + gbnw_pkg::t_cell'(1);
            end
            if (i_cmd.init) begin
                r_rp <= '0;
                r_wp <= gbnw_pkg::t_ptr'(1);
            end else begin
                if (i_cmd.deq) begin
                    r_rp <= r_rp + gbnw_pkg::t_ptr'(1);
                end
                if (visit_ok) begin
                    r_wp <= r_wp + gbnw_pkg::t_ptr'(1);
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start  <= i_start_req;
            r_target <= i_target;
        end
        if (i_cmd.take) begin
            r_p <= r_q_rd;
        end else if (i_cmd.walk_step) begin
            r_p <= walk_addr;
        end
        if (i_cmd.take) begin
            r_nb <= '0;
        end else if (i_cmd.nb_next) begin
            r_nb <= r_nb + gbnw_pkg::t_nb'(1);
        end
        if (i_cmd.walk_dir) begin
            r_dir <= r_step_rd;
        end
        if (i_cmd.emit) begin
            r_waypoint <= n_waypoint;
        end
    end

    // Status back to the controller
    always_comb begin
        o_stat.eq         = (r_start == r_target);
        o_stat.q_more     = (r_rp < r_wp)
                            && (r_rp < gbnw_pkg::t_ptr'(gbnw_pkg::CELL_COUNT));
        o_stat.p_is_start = (r_q_rd == r_start);
        o_stat.ex_bit     = r_ex_rd[r_nb];
        o_stat.nb_last    = (r_nb == gbnw_pkg::NB_DOWN);
        o_stat.same_dir   = (r_step_rd == r_dir);
        o_stat.clr_last   = (r_clr == gbnw_pkg::t_cell'(gbnw_pkg::CELL_COUNT - 1));
    end

    assign o_valid    = r_valid;
    assign o_waypoint = r_waypoint;

`ifndef SYNTH
    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= gbnw_pkg::t_ptr'(gbnw_pkg::CELL_COUNT))
        else $error("write pointer beyond queue depth");
    a_rp_le_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_wp)
        else $error("read pointer passed write pointer");
    a_beat_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats in a row");
`endif

endmodule

### hw/rtl/gbnw_ctrl.sv
// Controller: sequences clearing, flooding and the straight walk.
module gbnw_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_kind,
    input  gbnw_pkg::t_stat i_stat,
    output gbnw_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    typedef enum logic [11:0] {
        S_RST_CLR = 12'b0000_0000_0001,
        S_IDLE    = 12'b0000_0000_0010,
        S_CHECK   = 12'b0000_0000_0100,
        S_CLEAR   = 12'b0000_0000_1000,
        S_INIT    = 12'b0000_0001_0000,
        S_DEQ     = 12'b0000_0010_0000,
        S_TAKE    = 12'b0000_0100_0000,
        S_NB_RD   = 12'b0000_1000_0000,
        S_NB_CHK  = 12'b0001_0000_0000,
        S_WDIR    = 12'b0010_0000_0000,
        S_WSTEP   = 12'b0100_0000_0000,
        S_WCHK    = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Advance the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_cmd.sel = gbnw_pkg::SEL_TARGET;
        unique case (r_state)
            S_RST_CLR: begin
                o_cmd.clr       = 1'b1;
                o_cmd.clr_exits = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.wr_exits = !i_kind;
                    if (i_kind) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_stat.eq) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = gbnw_pkg::SEL_TARGET;
                    n_state    = S_IDLE;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_DEQ;
            end
            S_DEQ: begin
                if (i_stat.q_more) begin
                    o_cmd.deq = 1'b1;
                    n_state   = S_TAKE;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = gbnw_pkg::SEL_START;
                    n_state    = S_IDLE;
                end
            end
            S_TAKE: begin
                o_cmd.take = 1'b1;
                n_state    = i_stat.p_is_start ? S_WDIR : S_NB_RD;
            end
            S_NB_RD: begin
                if (i_stat.ex_bit) begin
                    o_cmd.nb_rd = 1'b1;
                    n_state     = S_NB_CHK;
                end else if (i_stat.nb_last) begin
                    n_state = S_DEQ;
                end else begin
                    o_cmd.nb_next = 1'b1;
                end
            end
            S_NB_CHK: begin
                o_cmd.visit = 1'b1;
                if (i_stat.nb_last) begin
                    n_state = S_DEQ;
                end else begin
                    o_cmd.nb_next = 1'b1;
                    n_state       = S_NB_RD;
                end
            end
            S_WDIR: begin
                o_cmd.walk_dir = 1'b1;
                n_state        = S_WSTEP;
            end
            S_WSTEP: begin
                o_cmd.walk_step = 1'b1;
                n_state         = S_WCHK;
            end
            S_WCHK: begin
                if (i_stat.same_dir) begin
                    n_state = S_WSTEP;
                end else begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = gbnw_pkg::SEL_WALK;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hw/rtl/grid_bfs_next_waypoint_core.sv
// Top level of the grid path planner: controller plus datapath.
// An exit mask write gives no result and leaves the block idle; a plan with equal
// start and target emits the target as its waypoint from a check state.
// Other plans clear the step store in a sweep, flood from the target until the start is
// dequeued, then walk straight from the start (or give the start if never reached), one at a time.
// After reset, busy stays high while a sweep clears the exit and step stores.
module grid_bfs_next_waypoint_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_kind,
    input  logic [7:0] i_cell_req,
    input  logic [3:0] i_exits,
    input  logic [7:0] i_start_req,
    input  logic [7:0] i_target,
    output logic       o_valid,
    output logic [7:0] o_waypoint
);

    gbnw_pkg::t_cmd  cmd;
    gbnw_pkg::t_stat stat;

    gbnw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_kind  (i_kind),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gbnw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cell_req  (i_cell_req),
        .i_exits     (i_exits),
        .i_start_req (i_start_req),
        .i_target    (i_target),
        .o_valid     (o_valid),
        .o_waypoint  (o_waypoint)
    );

endmodule

### tb/tb_grid_bfs_next_waypoint_core.sv
// Self-checking testbench for the grid path planner: mask writes, plan queries, waypoint checks.
`timescale 1ns / 1ps

module tb_grid_bfs_next_waypoint_core;
    import gbnw_pkg::*;

    localparam int STALL_LIMIT  = 30000;
    localparam int RANDOM_BEATS = 370;
    localparam int CALM_BEATS   = 60;
    localparam int TAIL_CYCLES  = 3000;
    localparam int RECENT_MAX   = 64;
    localparam int DIRECTED_N   = 24;

    localparam bit OP_MASK = 1'b0;
    localparam bit OP_PLAN = 1'b1;

    localparam bit BY_PREDICTOR = 1'b0;
    localparam bit BY_TABLE     = 1'b1;

    localparam t_exits EXIT_NONE  = 4'b0000;
    localparam t_exits EXIT_LEFT  = 4'b0001;
    localparam t_exits EXIT_RIGHT = 4'b0010;
    localparam t_exits EXIT_UP    = 4'b0100;
    localparam t_exits EXIT_DOWN  = 4'b1000;
    localparam t_exits EXIT_ALL   = 4'b1111;

    // One input beat plus an optional hand-typed waypoint
    typedef struct packed {
        bit     is_plan;
        t_cell  cell_idx;
        t_exits exits;
        t_cell  start_cell;
        t_cell  target_cell;
        bit     check_src;
        t_cell  fixed_wp;
    } t_beat;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_kind;
    logic [7:0] i_cell_req;
    logic [3:0] i_exits;
    logic [7:0] i_start_req;
    logic [7:0] i_target;
    logic       o_valid;
    logic [7:0] o_waypoint;

    // Side information that travels with the beat on the ports
    bit    cur_check_src;
    t_cell cur_fixed_wp;

    // Planner model state
    t_exits grid_exits [CELL_COUNT];
    t_dir   step_code  [CELL_COUNT];
    t_cell  bfs_queue  [CELL_COUNT];
    t_ptr   rd_ptr;
    t_ptr   wr_ptr;

    t_cell  waypoint_q  [$];
    t_beat  beat_plan   [$];
    t_cell  recent_cells[$];

    bit beat_taken   = 1'b0;
    int stall_cycles = 0;
    int errors       = 0;

    // Directed rows: equal cells, empty grid, edge wraps, straight runs, field extremes
    t_beat directed_rows [DIRECTED_N] = '{
        '{OP_PLAN, 8'hFF, EXIT_ALL,   8'h00, 8'h00, BY_TABLE,     8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'hFF, 8'hFF, BY_TABLE,     8'hFF},
        '{OP_PLAN, 8'h5A, EXIT_ALL,   8'h00, 8'hFF, BY_TABLE,     8'h00},
        '{OP_PLAN, 8'hA5, EXIT_NONE,  8'hFF, 8'h00, BY_TABLE,     8'hFF},
        '{OP_MASK, 8'hFF, EXIT_NONE,  8'hFF, 8'hFF, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'h00, EXIT_LEFT,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'hFF, 8'h00, BY_TABLE,     8'h00},
        '{OP_MASK, 8'h00, EXIT_UP,    8'hFF, 8'hFF, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'hFF, EXIT_ALL,   8'hF0, 8'h00, BY_TABLE,     8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'hFF, 8'h00, BY_TABLE,     8'hFF},
        '{OP_MASK, 8'hFF, EXIT_ALL,   8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h33, EXIT_ALL,   8'hFF, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'h14, EXIT_LEFT,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'h13, EXIT_LEFT,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'h12, EXIT_LEFT,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'h11, EXIT_LEFT,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'h10, 8'h14, BY_TABLE,     8'h14},
        '{OP_MASK, 8'h24, EXIT_UP,    8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'h10, 8'h24, BY_PREDICTOR, 8'h00},
        '{OP_MASK, 8'hFA, EXIT_DOWN,  8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'h0A, 8'hFA, BY_TABLE,     8'hFA},
        '{OP_MASK, 8'h0F, EXIT_RIGHT, 8'h00, 8'h00, BY_PREDICTOR, 8'h00},
        '{OP_PLAN, 8'h00, EXIT_NONE,  8'h10, 8'h0F, BY_TABLE,     8'h0F},
        '{OP_PLAN, 8'hFF, EXIT_ALL,   8'h00, 8'hFF, BY_PREDICTOR, 8'h00}
    };

    grid_bfs_next_waypoint_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_cell_req  (i_cell_req),
        .i_exits     (i_exits),
        .i_start_req (i_start_req),
        .i_target    (i_target),
        .o_valid     (o_valid),
        .o_waypoint  (o_waypoint)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    // Mark a newly reached cell with the step back toward its parent
    function automatic void enqueue_cell(t_cell n, t_dir back);
        if (step_code[n] == DIR_NONE && wr_ptr < t_ptr'(CELL_COUNT)) begin
            step_code[n] = back;
            bfs_queue[wr_ptr[CELL_W-1:0]] = n;
            wr_ptr = wr_ptr + t_ptr'(1);
        end
    endfunction

    // Flood from the target, then walk straight from the start until the step turns
    function automatic t_cell predict_waypoint(t_cell src, t_cell dst);
        t_cell p;
        t_dir  d;
        if (src == dst)
            return dst;
        foreach (step_code[i])
            step_code[i] = DIR_NONE;
        step_code[dst] = DIR_TARGET;
        bfs_queue[0] = dst;
        rd_ptr = '0;
        wr_ptr = t_ptr'(1);
        while (rd_ptr < wr_ptr && rd_ptr < t_ptr'(CELL_COUNT)) begin
            p = bfs_queue[rd_ptr[CELL_W-1:0]];
            rd_ptr = rd_ptr + t_ptr'(1);
            if (p == src) begin
                d = step_code[p];
                for (int k = 0; k < CELL_COUNT; k++) begin
                    case (d)
                        DIR_PLUS1:    p = p + t_cell'(1);
                        DIR_MINUS1:   p = p - t_cell'(1);
                        DIR_PLUSROW:  p = p + t_cell'(GRID_SIDE);
                        DIR_MINUSROW: p = p - t_cell'(GRID_SIDE);
                        default:      p = p;
                    endcase
                    if (step_code[p] != d)
                        break;
                end
                return p;
            end
            if (grid_exits[p] & EXIT_LEFT)
                enqueue_cell(p - t_cell'(1), DIR_PLUS1);
            if (grid_exits[p] & EXIT_RIGHT)
                enqueue_cell(p + t_cell'(1), DIR_MINUS1);
            if (grid_exits[p] & EXIT_UP)
                enqueue_cell(p - t_cell'(GRID_SIDE), DIR_PLUSROW);
            if (grid_exits[p] & EXIT_DOWN)
                enqueue_cell(p + t_cell'(GRID_SIDE), DIR_MINUSROW);
        end
        return src;
    endfunction

    // Sample accepted beats and waypoints at the rising edge
    always @(posedge i_clk) begin : scoreboard
        t_cell want;
        beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid) begin
                if (waypoint_q.size() == 0) begin
                    report_mismatch("unexpected waypoint", o_waypoint, 0);
                end else begin
                    want = waypoint_q.pop_front();
                    if (o_waypoint !== want)
                        report_mismatch("waypoint", o_waypoint, want);
                end
            end
            if (start && !busy) begin
                beat_taken = 1'b1;
                if (i_kind == OP_PLAN) begin
                    want = predict_waypoint(i_start_req, i_target);
                    if (cur_check_src == BY_TABLE)
                        want = cur_fixed_wp;
                    waypoint_q.push_back(want);
                end else begin
                    grid_exits[i_cell_req] = i_exits;
                end
            end
            if (beat_taken || o_valid)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    function automatic t_beat mask_beat(t_cell c, t_exits e);
        t_beat b;
        b = '{OP_MASK, c, e, t_cell'($urandom), t_cell'($urandom), BY_PREDICTOR, 8'h00};
        return b;
    endfunction

    function automatic t_beat plan_beat(t_cell src, t_cell dst);
        t_beat b;
        b = '{OP_PLAN, t_cell'($urandom), t_exits'($urandom), src, dst, BY_PREDICTOR, 8'h00};
        return b;
    endfunction

    // Mostly open cells so floods spread; sometimes any mask
    function automatic t_exits rand_exits();
        if ($urandom_range(0, 3) == 0)
            return t_exits'($urandom);
        return t_exits'($urandom | $urandom);
    endfunction

    function automatic t_cell pick_cell();
        if (recent_cells.size() == 0 || $urandom_range(0, 5) == 0)
            return t_cell'($urandom);
        return recent_cells[$urandom_range(0, recent_cells.size() - 1)];
    endfunction

    function automatic void remember_cell(t_cell c);
        recent_cells.push_back(c);
        if (recent_cells.size() > RECENT_MAX)
            void'(recent_cells.pop_front());
    endfunction

    // Queue up a batch: corridor, scattered masks, plan queries or noise
    task automatic build_batch();
        int    pick;
        int    len;
        int    n;
        t_cell c0;
        t_cell c;
        t_cell stride;
        t_cell base;
        t_exits axis;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            c0 = pick_cell();
            stride = $urandom_range(0, 1) ? t_cell'(1) : t_cell'(GRID_SIDE);
            axis = (stride == t_cell'(1)) ? (EXIT_LEFT | EXIT_RIGHT) : (EXIT_UP | EXIT_DOWN);
            len = $urandom_range(2, 8);
            c = c0;
            for (int i = 0; i < len; i++) begin
                c = c0 + t_cell'(i) * stride;
                beat_plan.push_back(mask_beat(c, axis | t_exits'($urandom & $urandom)));
                remember_cell(c);
            end
            beat_plan.push_back(plan_beat(c0, c));
            if ($urandom_range(0, 1))
                beat_plan.push_back(plan_beat(c, c0));
            beat_plan.push_back(plan_beat(pick_cell(), c));
        end else if (pick < 6) begin
            base = t_cell'($urandom_range(0, GRID_SIDE - 1) * GRID_SIDE);
            n = $urandom_range(4, 12);
            for (int i = 0; i < n; i++) begin
                c = base + t_cell'($urandom_range(0, 63));
                beat_plan.push_back(mask_beat(c, rand_exits()));
                remember_cell(c);
            end
        end else if (pick < 9) begin
            n = $urandom_range(2, 5);
            for (int i = 0; i < n; i++) begin
                c = pick_cell();
                if ($urandom_range(0, 7) == 0)
                    beat_plan.push_back(plan_beat(c, c));
                else
                    beat_plan.push_back(plan_beat(pick_cell(), c));
            end
        end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                beat_plan.push_back('{bit'($urandom), t_cell'($urandom), t_exits'($urandom),
                                      t_cell'($urandom), t_cell'($urandom), BY_PREDICTOR,
                                      8'h00});
        end
    endtask

    // Present one beat and hold it until the block takes it
    task automatic send_beat(input t_beat b, input bit allow_gaps);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            i_kind <= 1'($urandom);
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_kind        <= b.is_plan;
        i_cell_req    <= b.cell_idx;
        i_exits       <= b.exits;
        i_start_req   <= b.start_cell;
        i_target      <= b.target_cell;
        cur_check_src <= b.check_src;
        cur_fixed_wp  <= b.fixed_wp;
        do @(negedge i_clk); while (!beat_taken);
    endtask

    // Hold off the sender until every waypoint has arrived
    task automatic wait_for_waypoints();
        start <= 1'b0;
        do @(negedge i_clk); while (waypoint_q.size() != 0);
    endtask

    initial begin : stimulus
        int    sent;
        t_beat b;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = OP_MASK;
        i_cell_req    = '0;
        i_exits       = '0;
        i_start_req   = '0;
        i_target      = '0;
        cur_check_src = BY_PREDICTOR;
        cur_fixed_wp  = '0;
        rd_ptr        = '0;
        wr_ptr        = '0;
        foreach (grid_exits[i]) begin
            grid_exits[i] = EXIT_NONE;
            step_code[i]  = DIR_NONE;
            bfs_queue[i]  = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < DIRECTED_N; r++)
            send_beat(directed_rows[r], 1'b1);
        wait_for_waypoints();

        // Random batches; gaps and drains stop near the end
        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if (beat_plan.size() == 0)
                build_batch();
            b = beat_plan.pop_front();
            if (sent < RANDOM_BEATS - CALM_BEATS && $urandom_range(0, 39) == 0)
                wait_for_waypoints();
            send_beat(b, sent < RANDOM_BEATS - CALM_BEATS);
            sent++;
        end

        // Drain, then watch for stray waypoints
        wait_for_waypoints();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (waypoint_q.size() != 0)
            report_mismatch("waypoints never delivered", 0, waypoint_q.size());
        if (errors == 0)
            $display("PASS grid_bfs_next_waypoint_core");
        else
            $display("FAIL grid_bfs_next_waypoint_core");
        $finish;
    end

    // End the run if nothing moves for too long
    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("FAIL grid_bfs_next_waypoint_core");
        $finish;
    end

endmodule

### files.f
hw/rtl/gbnw_pkg.sv
hw/rtl/gbnw_dp.sv
hw/rtl/gbnw_ctrl.sv
hw/rtl/grid_bfs_next_waypoint_core.sv
tb/tb_grid_bfs_next_waypoint_core.sv
